// ===== hdl/bmpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpsd_pkg: shared types and constants of the BMP stream decoder
// Result item layout, result kinds, error codes and default sizes.
// ----------------------------------------------------------------------------
package bmpsd_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int DEF_MAX_DIM       = 4096;
   localparam int DEF_PALETTE_DEPTH = 256;

   // Fixed field widths of the stream ports.
   localparam int BYTE_W   = 8;
   localparam int CODE_W   = 2;
   localparam int COORD_W  = 12;
   localparam int COLOR_W  = 24;
   localparam int RSP_DATA_W = 56;

   // Byte position counter; saturates, which keeps every offset compare exact.
   localparam int POS_W = 34;

   localparam int unsigned MIN_INFO_SIZE   = 40;
   localparam int unsigned BPP_TRUE        = 24;
   localparam int unsigned BPP_INDEXED     = 8;
   localparam int unsigned FILE_HEADER_LEN = 14;
   localparam int unsigned HEADER_END      = 50;
   localparam int unsigned FULL_PALETTE    = 256;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_ERROR = 1'b1
   } kind_type;

   typedef enum logic [CODE_W-1:0] {
      ERR_SHORT_HEADER = 2'd0,
      ERR_BAD_BPP      = 2'd1,
      ERR_COMPRESSED   = 2'd2,
      ERR_TOO_LARGE    = 2'd3
   } err_code_type;

   // Result under way between the parser register and the output register.
   typedef struct packed {
      kind_type             kind;
      err_code_type         code;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic [COLOR_W-1:0]   color;
      logic                 use_palette;
      logic                 last;
   } mid_item_type;

endpackage

// ===== hdl/bmpsd_ram.sv =====
// ----------------------------------------------------------------------------
// bmpsd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when disabled.
// ----------------------------------------------------------------------------
module bmpsd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bmpsd_parser.sv =====
// ----------------------------------------------------------------------------
// bmpsd_parser: header, palette and pixel parser
// Consumes one file byte per accepted word, keeps the parse state and loads
// the palette RAM. Results go to a pipeline register; indexed pixels also
// launch a palette read that lands alongside that register.
// ----------------------------------------------------------------------------
module bmpsd_parser import bmpsd_pkg::*; #(
   parameter int MAX_DIM       = DEF_MAX_DIM,
   parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             req_tvalid,
   input  logic [BYTE_W-1:0]                req_byte,
   input  logic                             req_first,
   output logic                             pal_wr_en,
   output logic [$clog2(PALETTE_DEPTH)-1:0] pal_wr_addr,
   output logic [COLOR_W-1:0]               pal_wr_data,
   output logic                             pal_rd_en,
   output logic [$clog2(PALETTE_DEPTH)-1:0] pal_rd_addr,
   output logic                             mid_valid,
   output mid_item_type                     mid_item
);

   localparam int AW    = $clog2(PALETTE_DEPTH);
   localparam int PCW   = $clog2(PALETTE_DEPTH + 1);
   localparam int DIM_W = $clog2(MAX_DIM + 1);

   // Header byte offsets: first and last byte of each little-endian field.
   localparam logic [5:0] OFS_DATA        = 6'd10;
   localparam logic [5:0] OFS_DATA_LAST   = 6'd13;
   localparam logic [5:0] OFS_INFO        = 6'd14;
   localparam logic [5:0] OFS_INFO_LAST   = 6'd17;
   localparam logic [5:0] OFS_WIDTH       = 6'd18;
   localparam logic [5:0] OFS_WIDTH_LAST  = 6'd21;
   localparam logic [5:0] OFS_HEIGHT      = 6'd22;
   localparam logic [5:0] OFS_HEIGHT_LAST = 6'd25;
   localparam logic [5:0] OFS_BPP         = 6'd28;
   localparam logic [5:0] OFS_BPP_LAST    = 6'd29;
   localparam logic [5:0] OFS_COMP        = 6'd30;
   localparam logic [5:0] OFS_COMP_LAST   = 6'd33;
   localparam logic [5:0] OFS_PAL         = 6'd46;
   localparam logic [5:0] OFS_PAL_LAST    = 6'd49;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_BODY,
      PH_DONE
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [1:0]         shift_ff, shift_in;
   logic [31:0]        acc_ff, acc_in;
   logic [31:0]        pix_start_ff, pix_start_in;
   logic [32:0]        pal_start_ff, pal_start_in;
   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic               big_ff, big_in;
   logic               pal_mode_ff, pal_mode_in;
   logic [PCW-1:0]     pal_entries_ff, pal_entries_in;
   logic [PCW-1:0]     pal_loaded_ff, pal_loaded_in;
   logic [DIM_W-1:0]   col_ff, col_in;
   logic [DIM_W-1:0]   row_ff, row_in;
   logic [1:0]         bip_ff, bip_in;
   logic [1:0]         pad_ff, pad_in;
   logic [15:0]        partial_ff, partial_in;
   logic               mid_valid_ff, mid_valid_in;
   mid_item_type       mid_ff, mid_in;

   logic               accept;
   logic [5:0]         hdr_pos;
   logic               fld_start;
   logic [31:0]        acc_next;
   logic [31:0]        pal_len;
   logic [POS_W-1:0]   pal_off;
   logic [POS_W-3:0]   pal_entry;
   logic [DIM_W-1:0]   col_next;
   logic [DIM_W-1:0]   row_next;
   logic               pixel_done;

   assign accept    = req_tvalid & advance;
   assign hdr_pos   = pos_ff[5:0];
   assign fld_start = hdr_pos inside {OFS_DATA, OFS_INFO, OFS_WIDTH, OFS_HEIGHT,
                                      OFS_BPP, OFS_COMP, OFS_PAL};
   assign acc_next  = (fld_start ? 32'd0 : acc_ff) |
                      ({24'd0, req_byte} << {(fld_start ? 2'd0 : shift_ff), 3'd0});
   assign pal_len   = (acc_next == 32'd0) ? 32'(FULL_PALETTE) : acc_next;
   assign pal_off   = pos_ff - POS_W'(pal_start_ff);
   assign pal_entry = pal_off[POS_W-1:2];
   assign col_next  = col_ff + DIM_W'(1);
   assign row_next  = row_ff + DIM_W'(1);

   always_comb begin
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      shift_in       = shift_ff;
      acc_in         = acc_ff;
      pix_start_in   = pix_start_ff;
      pal_start_in   = pal_start_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      big_in         = big_ff;
      pal_mode_in    = pal_mode_ff;
      pal_entries_in = pal_entries_ff;
      pal_loaded_in  = pal_loaded_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      bip_in         = bip_ff;
      pad_in         = pad_ff;
      partial_in     = partial_ff;
      mid_valid_in   = 1'b0;
      mid_in         = '0;
      pixel_done     = 1'b0;
      pal_wr_en      = 1'b0;
      pal_wr_addr    = pal_off[AW+1:2];
      pal_wr_data    = {req_byte, partial_ff};

      if (accept) begin
         if (req_first) begin
            // Byte 0 of a new file never lies inside a header field.
            phase_in       = PH_HEADER;
            pos_in         = POS_W'(1);
            shift_in       = 2'd0;
            acc_in         = 32'd0;
            pix_start_in   = 32'd0;
            pal_start_in   = 33'd0;
            width_in       = '0;
            height_in      = '0;
            big_in         = 1'b0;
            pal_mode_in    = 1'b0;
            pal_entries_in = '0;
            pal_loaded_in  = '0;
            col_in         = '0;
            row_in         = '0;
            bip_in         = 2'd0;
            pad_in         = 2'd0;
            partial_in     = 16'd0;
         end else begin
            if (pos_ff != '1) begin
               pos_in = pos_ff + POS_W'(1);
            end
            case (phase_ff)
               PH_HEADER: begin
                  if (hdr_pos inside {[OFS_DATA:OFS_HEIGHT_LAST], [OFS_BPP:OFS_COMP_LAST],
                                      [OFS_PAL:OFS_PAL_LAST]}) begin
                     acc_in   = acc_next;
                     shift_in = (fld_start ? 2'd0 : shift_ff) + 2'd1;
                     case (hdr_pos)
                        OFS_DATA_LAST: begin
                           pix_start_in = (acc_next > 32'(HEADER_END)) ? acc_next :
                                          32'(HEADER_END);
                        end
                        OFS_INFO_LAST: begin
                           pal_start_in = 33'(acc_next) + 33'(FILE_HEADER_LEN);
                           if (acc_next < 32'(MIN_INFO_SIZE)) begin
                              mid_valid_in = 1'b1;
                              mid_in.kind  = KIND_ERROR;
                              mid_in.code  = ERR_SHORT_HEADER;
                              phase_in     = PH_DONE;
                           end
                        end
                        OFS_WIDTH_LAST: begin
                           width_in = DIM_W'(acc_next);
                           big_in   = acc_next > 32'(MAX_DIM);
                        end
                        OFS_HEIGHT_LAST: begin
                           height_in = DIM_W'(acc_next);
                           big_in    = big_ff | (acc_next > 32'(MAX_DIM));
                        end
                        OFS_BPP_LAST: begin
                           if (acc_next[15:0] != 16'(BPP_TRUE) &&
                               acc_next[15:0] != 16'(BPP_INDEXED)) begin
                              mid_valid_in = 1'b1;
                              mid_in.kind  = KIND_ERROR;
                              mid_in.code  = ERR_BAD_BPP;
                              phase_in     = PH_DONE;
                           end
                           pal_mode_in = acc_next[15:0] == 16'(BPP_INDEXED);
                        end
                        OFS_COMP_LAST: begin
                           if (acc_next != 32'd0) begin
                              mid_valid_in = 1'b1;
                              mid_in.kind  = KIND_ERROR;
                              mid_in.code  = ERR_COMPRESSED;
                              phase_in     = PH_DONE;
                           end else if (big_ff) begin
                              mid_valid_in = 1'b1;
                              mid_in.kind  = KIND_ERROR;
                              mid_in.code  = ERR_TOO_LARGE;
                              phase_in     = PH_DONE;
                           end
                        end
                        OFS_PAL_LAST: begin
                           if (!pal_mode_ff) begin
                              pal_entries_in = '0;
                           end else if (pal_len < 32'(PALETTE_DEPTH)) begin
                              pal_entries_in = PCW'(pal_len);
                           end else begin
                              pal_entries_in = PCW'(PALETTE_DEPTH);
                           end
                           pal_loaded_in = '0;
                           phase_in = (width_ff == '0 || height_ff == '0) ? PH_DONE : PH_BODY;
                        end
                        default: ;
                     endcase
                  end
               end
               PH_BODY: begin
                  if (pos_ff >= POS_W'(pix_start_ff)) begin
                     if (pad_ff != 2'd0) begin
                        pad_in = pad_ff - 2'd1;
                     end else if (pal_mode_ff) begin
                        pixel_done         = 1'b1;
                        mid_in.use_palette = 9'(req_byte) < 9'(pal_loaded_ff);
                     end else if (bip_ff == 2'd0) begin
                        partial_in = {8'd0, req_byte};
                        bip_in     = 2'd1;
                     end else if (bip_ff == 2'd1) begin
                        partial_in = {req_byte, partial_ff[7:0]};
                        bip_in     = 2'd2;
                     end else begin
                        pixel_done   = 1'b1;
                        mid_in.color = {req_byte, partial_ff};
                        bip_in       = 2'd0;
                     end
                     if (pixel_done) begin
                        mid_valid_in = 1'b1;
                        mid_in.kind  = KIND_PIXEL;
                        mid_in.x     = COORD_W'(col_ff);
                        mid_in.y     = COORD_W'(height_ff - DIM_W'(1) - row_ff);
                        mid_in.last  = (col_next == width_ff) && (row_next == height_ff);
                        col_in       = col_next;
                        if (col_next == width_ff) begin
                           col_in = '0;
                           row_in = row_next;
                           // Rows pad to 4 bytes: -w mod 4 for 1 byte/px, w mod 4 for 3.
                           pad_in = pal_mode_ff ? 2'd0 - 2'(width_ff) : 2'(width_ff);
                           if (row_next == height_ff) begin
                              phase_in = PH_DONE;
                           end
                        end
                     end
                  end else if (pal_mode_ff && pos_ff >= POS_W'(pal_start_ff) &&
                               pal_entry < (POS_W-2)'(pal_entries_ff)) begin
                     case (pal_off[1:0])
                        2'd0: partial_in = {8'd0, req_byte};
                        2'd1: partial_in = {req_byte, partial_ff[7:0]};
                        2'd2: begin
                           pal_wr_en     = 1'b1;
                           pal_loaded_in = PCW'(pal_entry) + PCW'(1);
                        end
                        default: ;
                     endcase
                  end
               end
               default: ;
            endcase
         end
      end
   end

   assign pal_rd_en   = advance;
   assign pal_rd_addr = req_byte[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         pos_ff         <= '0;
         shift_ff       <= 2'd0;
         acc_ff         <= 32'd0;
         pix_start_ff   <= 32'd0;
         pal_start_ff   <= 33'd0;
         width_ff       <= '0;
         height_ff      <= '0;
         big_ff         <= 1'b0;
         pal_mode_ff    <= 1'b0;
         pal_entries_ff <= '0;
         pal_loaded_ff  <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         bip_ff         <= 2'd0;
         pad_ff         <= 2'd0;
         partial_ff     <= 16'd0;
         mid_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         shift_ff       <= shift_in;
         acc_ff         <= acc_in;
         pix_start_ff   <= pix_start_in;
         pal_start_ff   <= pal_start_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         big_ff         <= big_in;
         pal_mode_ff    <= pal_mode_in;
         pal_entries_ff <= pal_entries_in;
         pal_loaded_ff  <= pal_loaded_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         bip_ff         <= bip_in;
         pad_ff         <= pad_in;
         partial_ff     <= partial_in;
         if (advance) begin
            mid_valid_ff <= mid_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mid_ff <= mid_in;
      end
   end

   assign mid_valid = mid_valid_ff;
   assign mid_item  = mid_ff;

endmodule

// ===== hdl/bmp_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// bmp_stream_decoder: streaming decoder for 8 and 24 bpp BMP files
// Parses the header, loads the palette and emits RGB pixels bottom row first,
// or one error word that ends the file.
//
//  channel  direction  tdata                              tuser       tlast
//  req_     in         [7:0] file_byte                    first_byte  -
//  rsp_     out        error_code, pixel_x, pixel_y, rgb  kind        last_pixel
//
// One byte is accepted every cycle while the output side keeps up. A result
// passes through the parser register and palette RAM read, then the output
// register, before it appears on rsp_. The output register lets req_ keep
// moving while a result waits; input stalls only when both the parser
// register and the output register are full. Reset is synchronous and
// needs no clearing pass: palette data is used only for loaded entries.
// ----------------------------------------------------------------------------
module bmp_stream_decoder import bmpsd_pkg::*; #(
   parameter int MAX_DIM       = DEF_MAX_DIM,
   parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] file_byte
   input  logic                  req_tuser,   // first_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] error_code, [13:2] pixel_x, [25:14] pixel_y, [33:26] red,
   // [41:34] green, [49:42] blue, [55:50] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,   // kind
   output logic                  rsp_tlast    // last_pixel
);

   localparam int AW = $clog2(PALETTE_DEPTH);

   logic               advance;
   logic               out_free;
   logic               pal_wr_en;
   logic [AW-1:0]      pal_wr_addr;
   logic [COLOR_W-1:0] pal_wr_data;
   logic               pal_rd_en;
   logic [AW-1:0]      pal_rd_addr;
   logic [COLOR_W-1:0] pal_rd_data;
   logic               mid_valid;
   mid_item_type       mid_item;
   logic [COLOR_W-1:0] color;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_kind_ff;
   logic                  rsp_last_ff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = !mid_valid || out_free;
   assign req_tready = advance;

   bmpsd_parser #(
      .MAX_DIM       (MAX_DIM),
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_tvalid  (req_tvalid),
      .req_byte    (req_tdata),
      .req_first   (req_tuser),
      .pal_wr_en   (pal_wr_en),
      .pal_wr_addr (pal_wr_addr),
      .pal_wr_data (pal_wr_data),
      .pal_rd_en   (pal_rd_en),
      .pal_rd_addr (pal_rd_addr),
      .mid_valid   (mid_valid),
      .mid_item    (mid_item)
   );

   bmpsd_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (pal_wr_addr),
      .wr_data (pal_wr_data),
      .rd_en   (pal_rd_en),
      .rd_addr (pal_rd_addr),
      .rd_data (pal_rd_data)
   );

   // Indexed pixels take their color from the palette read issued with the byte;
   // an index without a loaded entry leaves the color at black.
   assign color = mid_item.use_palette ? pal_rd_data : mid_item.color;

   assign rsp_data_in = {6'd0, color[7:0], color[15:8], color[23:16],
                         mid_item.y, mid_item.x, mid_item.code};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= mid_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= mid_item.kind;
         rsp_last_ff <= mid_item.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
